>>> sv/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants
// Command codes, register indexes and result widths of the PWM period and
// duty capture block.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int DATA_W     = 32;  // capture, register and tick field width
  localparam int FREQ_W     = 40;  // frequency_q8 width (Q32.8)
  localparam int DUTY_W     = 15;  // duty_q8 width (Q7.8 percent)
  localparam int FRAC_W     = 8;   // fraction bits of both results
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;

  // Largest duty result: 100 percent in Q.8.
  localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;

  typedef enum logic [CMD_W-1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELOAD     = 1'b0,
    REG_TICK_CLOCK = 1'b1
  } reg_idx_t;

endpackage

>>> sv/pwm_period_duty_capture_core.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_capture_core: PWM input period and duty measurement
// Turns down-counter capture, timeout and restart events into a snapshot of
// period, high time, frequency and duty cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one timer event per beat:
//   command, period_latch, high_latch. Every event yields exactly one
//   result beat on the output channel (out_valid/out_ready).
//   Config channel (cfg_valid/cfg_ready) writes reload_value (index 0) or
//   tick_clock_hz (index 1); it is always ready and is meant for idle time.
//   An event that leaves a valid measurement runs two bit-serial dividers
//   side by side, a 40-bit frequency divider and a 15-bit duty divider,
//   before the result is loaded; an event without a valid measurement
//   goes straight from idle to the done state. The frequency divider, the
//   wider of the two, sets how often the block can take a new event.
//   in_ready is high only between events; the output register holds a
//   finished beat while the next event is accepted and worked on.
//   If the receiver stalls, the next result waits in the done state.
//   Synchronous reset clears the measurement, synchronization and the
//   output valid, and loads reload_value 65535 and tick_clock_hz 32000000.
// ----------------------------------------------------------------------------
module pwm_period_duty_capture_core
  import pdc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [DATA_W-1:0]    period_latch,
  input  logic [DATA_W-1:0]    high_latch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    period_len,
  output logic [DATA_W-1:0]    high_len,
  output logic                 measurement_valid,
  output logic [FREQ_W-1:0]    frequency_q8,
  output logic [DUTY_W-1:0]    duty_q8,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int CW  = COUNT_WIDTH;
  localparam int DDW = CW + DUTY_W;  // width of high * 25600

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [DATA_W-1:0] reload_value;
  logic [DATA_W-1:0] tick_clock_hz;

  logic          synchronized;
  logic [CW-1:0] stored_period;
  logic [CW-1:0] stored_high;
  logic          stored_valid;

  logic          in_fire;
  logic          out_free;
  logic [CW-1:0] per_new;
  logic [CW-1:0] hi_new;
  logic          cap_ok;
  logic          valid_next;

  logic              div_start;
  logic [DDW-1:0]    duty_dividend;
  logic              freq_busy;
  logic              duty_busy;
  logic [FREQ_W-1:0] freq_quot;
  logic [DUTY_W-1:0] duty_quot;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign div_start = (state == ST_LAUNCH);

  always_comb begin
    per_new = reload_value[CW-1:0] - period_latch[CW-1:0];
    hi_new  = reload_value[CW-1:0] - high_latch[CW-1:0];
    cap_ok  = (per_new != '0) && (hi_new <= per_new);
    case (command)
      CMD_CAPTURE:             valid_next = synchronized ? cap_ok : stored_valid;
      CMD_TIMEOUT,
      CMD_RESTART:             valid_next = 1'b0;
      default:                 valid_next = stored_valid;
    endcase
  end

  // 25600 = 2^14 + 2^13 + 2^10
  assign duty_dividend = (DDW'(stored_high) << 14) + (DDW'(stored_high) << 13)
                       + (DDW'(stored_high) << 10);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = valid_next ? ST_LAUNCH : ST_DONE;
      ST_LAUNCH: state_next = ST_CALC;
      ST_CALC:   if (!freq_busy && !duty_busy) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value  <= 32'd65535;
      tick_clock_hz <= 32'd32000000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RELOAD:     reload_value  <= cfg_data;
        REG_TICK_CLOCK: tick_clock_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synchronized  <= 1'b0;
      stored_period <= '0;
      stored_high   <= '0;
      stored_valid  <= 1'b0;
    end else if (in_fire) begin
      stored_valid <= valid_next;
      case (command)
        CMD_CAPTURE: begin
          if (synchronized) begin
            stored_period <= per_new;
            stored_high   <= hi_new;
          end else begin
            synchronized <= 1'b1;
          end
        end
        CMD_TIMEOUT,
        CMD_RESTART: synchronized <= 1'b0;
        default: ;
      endcase
    end
  end

  pdc_div #(
    .CW (CW),
    .NB (FREQ_W)
  ) u_freq_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .init_rem ('0),
    .dividend ({tick_clock_hz, {FRAC_W{1'b0}}}),
    .divisor  (stored_period),
    .busy     (freq_busy),
    .quotient (freq_quot)
  );

  // The top bits of high * 25600 stay below the period, so they seed the
  // remainder and only the low quotient bits need iterations.
  pdc_div #(
    .CW (CW),
    .NB (DUTY_W)
  ) u_duty_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .init_rem (duty_dividend[DDW-1:DUTY_W]),
    .dividend (duty_dividend[DUTY_W-1:0]),
    .divisor  (stored_period),
    .busy     (duty_busy),
    .quotient (duty_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      period_len        <= DATA_W'(stored_period);
      high_len          <= DATA_W'(stored_high);
      measurement_valid <= stored_valid;
      status            <= !stored_valid;
      frequency_q8      <= stored_valid ? freq_quot : '0;
      duty_q8           <= stored_valid ? duty_quot : '0;
    end
  end

endmodule

>>> sv/pdc_div.sv
// ----------------------------------------------------------------------------
// pdc_div: radix-2 restoring divider
// Shifts one dividend bit per cycle into a partial remainder, compares it
// with the divisor and shifts the quotient bit back into the same register.
// ----------------------------------------------------------------------------
module pdc_div #(
  parameter int CW = 32,  // divisor and remainder width
  parameter int NB = 40   // dividend bits, equal to quotient bits
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] init_rem,
  input  logic [NB-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          busy,
  output logic [NB-1:0] quotient
);

  localparam int CNT_W = $clog2(NB + 1);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    rem_next;
  logic [NB-1:0]    work;
  logic [CNT_W-1:0] cnt;
  logic [CW:0]      trial;
  logic [CW:0]      diff;
  logic             fits;

  always_comb begin
    trial    = {rem, work[NB-1]};
    fits     = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    rem_next = fits ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NB);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= init_rem;
      work <= dividend;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[NB-2:0], fits};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = work;

endmodule

>>> sv/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker: port-level checks of the capture core
// Watches the result channel for consistent status, zeroed results on no data,
// bounded period, high time and duty on valid data, and a held beat on a stall.
// ----------------------------------------------------------------------------
module pdc_checker
  import pdc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] period_len,
  input logic [DATA_W-1:0] high_len,
  input logic              measurement_valid,
  input logic [FREQ_W-1:0] frequency_q8,
  input logic [DUTY_W-1:0] duty_q8,
  input logic              status
);

  a_status_matches_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != measurement_valid))
    else $error("status does not mirror measurement_valid");

  a_no_data_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (frequency_q8 == '0 && duty_q8 == '0))
    else $error("no-data beat carries nonzero frequency or duty");

  a_valid_bounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && measurement_valid) |->
      (period_len != '0 && high_len <= period_len && duty_q8 <= DUTY_FULL))
    else $error("valid beat out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(period_len) && $stable(frequency_q8) && $stable(duty_q8)))
    else $error("stalled result beat changed");

endmodule

bind pwm_period_duty_capture_core pdc_checker u_pdc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .period_len        (period_len),
  .high_len          (high_len),
  .measurement_valid (measurement_valid),
  .frequency_q8      (frequency_q8),
  .duty_q8           (duty_q8),
  .status            (status)
);

>>> dv/tb_pwm_period_duty_capture_core.sv
// ----------------------------------------------------------------------------
// tb_pwm_period_duty_capture_core: event-level check of the PWM capture core
// Drives capture, timeout, restart and unused events through the input
// channel and rebuilds each snapshot in a local measurement tracker. Every
// result beat is compared field by field against the oldest pending
// snapshot. Register settings change only between drained phases. Both
// channels idle at random, and one phase holds off the receiver long enough
// to back the block up.
// ----------------------------------------------------------------------------
module tb_pwm_period_duty_capture_core;
  import pdc_pkg::*;

  localparam int CNT_W = 32;
  localparam logic [DATA_W-1:0] CNT_MASK = {DATA_W{1'b1}} >> (DATA_W - CNT_W);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 260;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] high;
    logic              valid;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic              status;
  } snapshot_t;

  logic                 clk               = 1'b0;
  logic                 rst               = 1'b1;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command           = '0;
  logic [DATA_W-1:0]    period_latch      = '0;
  logic [DATA_W-1:0]    high_latch        = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic [DATA_W-1:0]    period_len;
  logic [DATA_W-1:0]    high_len;
  logic                 measurement_valid;
  logic [FREQ_W-1:0]    frequency_q8;
  logic [DUTY_W-1:0]    duty_q8;
  logic                 status;
  logic                 cfg_valid         = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [DATA_W-1:0]    cfg_data          = '0;

  // Local copy of the measurement state and registers
  logic              meas_synced  = 1'b0;
  logic [DATA_W-1:0] meas_period  = '0;
  logic [DATA_W-1:0] meas_high    = '0;
  logic              meas_valid   = 1'b0;
  logic [DATA_W-1:0] model_reload = 32'd65535;
  logic [DATA_W-1:0] model_tick   = 32'd32000000;

  snapshot_t expected_snapshots[$];
  int  errors       = 0;
  bit  steady       = 1'b0;
  bit  hold_request = 1'b0;
  int  stall_left   = 0;

  pwm_period_duty_capture_core #(
    .COUNT_WIDTH(CNT_W)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .period_latch     (period_latch),
    .high_latch       (high_latch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .period_len       (period_len),
    .high_len         (high_len),
    .measurement_valid(measurement_valid),
    .frequency_q8     (frequency_q8),
    .duty_q8          (duty_q8),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(21, 100);
  endfunction

  // Advance the measurement state by one event and return its snapshot
  function automatic snapshot_t predict_snapshot(input logic [CMD_W-1:0] cmd,
                                                 input logic [DATA_W-1:0] pcap,
                                                 input logic [DATA_W-1:0] hcap);
    logic [DATA_W-1:0] load;
    logic [63:0]       wide;
    snapshot_t         snap;
    load = model_reload & CNT_MASK;
    if (cmd == CMD_CAPTURE) begin
      if (meas_synced) begin
        meas_period = (load - (pcap & CNT_MASK)) & CNT_MASK;
        meas_high   = (load - (hcap & CNT_MASK)) & CNT_MASK;
        meas_valid  = (meas_period != '0) && (meas_high <= meas_period);
      end else begin
        meas_synced = 1'b1;
      end
    end else if (cmd == CMD_TIMEOUT || cmd == CMD_RESTART) begin
      meas_valid  = 1'b0;
      meas_synced = 1'b0;
    end
    snap        = '0;
    snap.period = meas_period;
    snap.high   = meas_high;
    snap.valid  = meas_valid;
    snap.status = !meas_valid;
    if (meas_valid) begin
      wide      = ({32'd0, model_tick} << FRAC_W) / {32'd0, meas_period};
      snap.freq = wide[FREQ_W-1:0];
      wide      = ({32'd0, meas_high} * {49'd0, DUTY_FULL}) / {32'd0, meas_period};
      snap.duty = wide[DUTY_W-1:0];
    end
    return snap;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    snapshot_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_snapshots.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual period %h",
                 $time, period_len);
        errors++;
      end else begin
        want = expected_snapshots.pop_front();
        check_field("period_len", want.period, period_len);
        check_field("high_len", want.high, high_len);
        check_field("measurement_valid", want.valid, measurement_valid);
        check_field("frequency_q8", want.freq, frequency_q8);
        check_field("duty_q8", want.duty, duty_q8);
        check_field("status", want.status, status);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      stall_left   = HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        stall_left = gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Leaves in_valid high on return; the caller sends again or drains
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] pcap,
                            input logic [DATA_W-1:0] hcap);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    period_latch <= pcap;
    high_latch   <= hcap;
    do @(posedge clk); while (!in_ready);
    expected_snapshots.push_back(predict_snapshot(cmd, pcap, hcap));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_snapshots.size() != 0) @(posedge clk);
  endtask

  task automatic set_registers(input logic [DATA_W-1:0] reload,
                               input logic [DATA_W-1:0] tick);
    cfg_valid <= 1'b1;
    cfg_index <= REG_RELOAD;
    cfg_data  <= reload;
    do @(posedge clk); while (!cfg_ready);
    model_reload = reload;
    cfg_index <= REG_TICK_CLOCK;
    cfg_data  <= tick;
    do @(posedge clk); while (!cfg_ready);
    model_tick = tick;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed captures against the current reload, some noise
  task automatic send_random_event();
    logic [DATA_W-1:0] load;
    logic [DATA_W-1:0] per;
    logic [DATA_W-1:0] hi;
    int                r;
    load = model_reload & CNT_MASK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: per = $urandom_range(1, 255);
      4, 5, 6:    per = $urandom_range(1, 65535);
      default:    per = $urandom();
    endcase
    if (per == '0) per = 1;
    case ($urandom_range(0, 9))
      0:       hi = '0;
      1:       hi = per;
      default: hi = $urandom_range(0, per);
    endcase
    r = $urandom_range(0, 99);
    if (r < 78) begin
      send_event(CMD_CAPTURE, load - per, load - hi);
    end else if (r < 84) begin
      // high longer than period, or zero period
      if (r < 81) send_event(CMD_CAPTURE, load - per, load - per - $urandom_range(1, 1000));
      else send_event(CMD_CAPTURE, load, load - hi);
    end else if (r < 89) begin
      send_event(CMD_TIMEOUT, $urandom(), $urandom());
    end else if (r < 94) begin
      send_event(CMD_RESTART, $urandom(), $urandom());
    end else if (r < 97) begin
      send_event(CMD_UNUSED, $urandom(), $urandom());
    end else begin
      send_event(CMD_W'($urandom_range(0, 3)), $urandom(), $urandom());
    end
  endtask

  // Reset register values, sync, validity edges and the unused code
  task automatic test_directed_defaults();
    send_event(CMD_RESTART, $urandom(), $urandom());
    send_event(CMD_CAPTURE, 32'h0000_1111, 32'h0000_2222);
    send_event(CMD_CAPTURE, 32'h0000_0000, 32'h0000_FFFF);
    send_event(CMD_CAPTURE, 32'h0000_8000, 32'h0000_0000);
    send_event(CMD_CAPTURE, 32'h0000_FFFF, 32'h0000_FFFF);
    send_event(CMD_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(CMD_UNUSED, $urandom(), $urandom());
    send_event(CMD_TIMEOUT, $urandom(), $urandom());
    send_event(CMD_CAPTURE, $urandom(), $urandom());
    send_event(CMD_CAPTURE, 32'h0000_1234, 32'h0000_5678);
    send_event(CMD_RESTART, $urandom(), $urandom());
    send_event(CMD_CAPTURE, $urandom(), $urandom());
    wait_results_drained();
  endtask

  // Register extremes, reload below its range and a zero tick clock
  task automatic test_directed_extremes();
    set_registers(32'd2, 32'hFFFF_FFFF);
    send_event(CMD_CAPTURE, 32'd1, 32'd2);
    send_event(CMD_CAPTURE, 32'd1, 32'd1);
    wait_results_drained();
    set_registers(32'hFFFF_FFFF, 32'd1);
    send_event(CMD_CAPTURE, 32'h0000_0000, 32'h0000_0000);
    send_event(CMD_CAPTURE, 32'h0000_0000, 32'hFFFF_FFFE);
    wait_results_drained();
    set_registers(32'd0, 32'd0);
    send_event(CMD_CAPTURE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(CMD_CAPTURE, 32'h8000_0000, 32'h8000_0001);
    wait_results_drained();
    set_registers(32'd1, 32'd32000000);
    send_event(CMD_TIMEOUT, $urandom(), $urandom());
    send_event(CMD_CAPTURE, $urandom(), $urandom());
    send_event(CMD_CAPTURE, 32'd0, 32'd0);
    wait_results_drained();
  endtask

  task automatic test_random_phases();
    logic [DATA_W-1:0] reload;
    logic [DATA_W-1:0] tick;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       begin reload = 32'd65535;                tick = 32'd32000000; end
        1:       begin reload = 32'd2;                    tick = 32'hFFFF_FFFF; end
        2:       begin reload = 32'hFFFF_FFFF;            tick = 32'd1; end
        3:       begin reload = $urandom_range(2, 65535); tick = $urandom(); end
        4:       begin reload = $urandom();  tick = $urandom_range(1, 100_000_000); end
        5:       begin reload = $urandom();               tick = $urandom(); end
        default: begin reload = 32'd1000;                 tick = 32'd0; end
      endcase
      set_registers(reload, tick);
      repeat (PHASE_ITEMS) send_random_event();
      wait_results_drained();
    end
  endtask

  task automatic test_no_idle();
    steady = 1'b1;
    repeat (150) send_random_event();
    wait_results_drained();
    steady = 1'b0;
  endtask

  // Hold the receiver off while events keep coming, so in_ready drops
  task automatic test_backpressure();
    set_registers($urandom_range(1000, 1_000_000), $urandom());
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_random_event();
    wait_results_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_directed_extremes();
    test_random_phases();
    test_no_idle();
    test_backpressure();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pdc_pkg.sv
sv/pdc_div.sv
sv/pwm_period_duty_capture_core.sv
sv/pdc_checker.sv
dv/tb_pwm_period_duty_capture_core.sv
